// ===== hw/rtl/cgb_pkg.sv =====
package cgb_pkg;

    localparam int unsigned CoordW = 12;
    localparam int unsigned ColourW = 8;
    localparam int unsigned AddrW = 24;
    localparam int unsigned GlyphW = 64;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 12;

    localparam logic [CfgIdxW-1:0] CFG_CLIP_LEFT   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_CLIP_TOP    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_CLIP_RIGHT  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_CLIP_BOTTOM = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_FORE_COLOUR = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_BACK_COLOUR = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_TRANS_MODE  = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_GRID_MODE   = 3'd7;

    localparam logic [1:0] TRANS_FG_ONLY = 2'd0;
    localparam logic [1:0] TRANS_BG_ONLY = 2'd1;
    localparam logic [1:0] TRANS_BOTH    = 2'd2;

    typedef struct packed {
        logic [CoordW-1:0]  clip_left;
        logic [CoordW-1:0]  clip_top;
        logic [CoordW-1:0]  clip_right;
        logic [CoordW-1:0]  clip_bottom;
        logic [ColourW-1:0] fore_colour;
        logic [ColourW-1:0] back_colour;
        logic [1:0]         trans_mode;
        logic               grid_mode;
    } cgb_cfg_t;

    typedef struct packed {
        logic [CoordW-1:0] x_col;
        logic [CoordW-1:0] y_row;
        logic [2:0]        x_skip;
        logic [2:0]        y_skip;
        logic [2:0]        x_last;
        logic [2:0]        y_last;
        logic [GlyphW-1:0] glyph_rows;
    } glyph_job_t;

endpackage

// ===== hw/rtl/cgb_if.sv =====
interface cgb_place_if
    import cgb_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic [GlyphW-1:0]        glyph_rows;

    modport source (output valid, output pos_x, output pos_y, output glyph_rows, input ready);
    modport sink (input valid, input pos_x, input pos_y, input glyph_rows, output ready);
endinterface

interface cgb_pixel_if
    import cgb_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [AddrW-1:0]   pixel_address;
    logic [ColourW-1:0] pixel_colour;
    logic               write_enable;
    logic               last_pixel;

    modport source (output valid, output pixel_address, output pixel_colour,
                    output write_enable, output last_pixel, input ready);
    modport sink (input valid, input pixel_address, input pixel_colour,
                  input write_enable, input last_pixel, output ready);
endinterface

// ===== hw/rtl/cgb_front.sv =====
module cgb_front
    import cgb_pkg::*;
(
    input  cgb_cfg_t          cfg,
    input  logic signed [CoordW-1:0] pos_x,
    input  logic signed [CoordW-1:0] pos_y,
    input  logic [GlyphW-1:0] glyph_rows,
    output logic              visible,
    output glyph_job_t        job
);

    logic signed [17:0] x_ext;
    logic signed [17:0] y_ext;
    logic signed [17:0] x_pos;
    logic signed [17:0] y_pos;
    logic signed [17:0] left_s;
    logic signed [17:0] top_s;
    logic signed [17:0] right_s;
    logic signed [17:0] bottom_s;
    logic signed [17:0] x_last0;
    logic signed [17:0] y_last0;
    logic signed [17:0] x_skip_s;
    logic signed [17:0] y_skip_s;
    logic signed [17:0] x_last_s;
    logic signed [17:0] y_last_s;
    logic [CoordW-1:0]  x_col;
    logic [CoordW-1:0]  y_row;

    always_comb
    begin
        x_ext    = 18'(pos_x);
        y_ext    = 18'(pos_y);
        x_pos    = cfg.grid_mode ? (x_ext <<< 3) : x_ext;
        y_pos    = cfg.grid_mode ? (y_ext <<< 3) : y_ext;
        left_s   = $signed({6'd0, cfg.clip_left});
        top_s    = $signed({6'd0, cfg.clip_top});
        right_s  = $signed({6'd0, cfg.clip_right});
        bottom_s = $signed({6'd0, cfg.clip_bottom});

        x_last0 = (x_pos + 18'sd7 > right_s) ? right_s - x_pos : 18'sd7;
        y_last0 = (y_pos + 18'sd7 > bottom_s) ? bottom_s - y_pos : 18'sd7;

        if (x_pos < left_s)
        begin
            x_skip_s = left_s - x_pos;
            x_col    = cfg.clip_left;
        end
        else
        begin
            x_skip_s = 18'sd0;
            x_col    = x_pos[CoordW-1:0];
        end

        if (y_pos < top_s)
        begin
            y_skip_s = top_s - y_pos;
            y_row    = cfg.clip_top;
        end
        else
        begin
            y_skip_s = 18'sd0;
            y_row    = y_pos[CoordW-1:0];
        end

        x_last_s = x_last0 - x_skip_s;
        y_last_s = y_last0 - y_skip_s;
        visible  = !x_last_s[17] && !y_last_s[17];

        job.x_col      = x_col;
        job.y_row      = y_row;
        job.x_skip     = x_skip_s[2:0];
        job.y_skip     = y_skip_s[2:0];
        job.x_last     = x_last_s[2:0];
        job.y_last     = y_last_s[2:0];
        job.glyph_rows = glyph_rows;
    end

endmodule

// ===== hw/rtl/cgb_job_fifo.sv =====
module cgb_job_fifo
    import cgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  glyph_job_t push_job,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output glyph_job_t head
);

    glyph_job_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/cgb_back.sv =====
module cgb_back
    import cgb_pkg::*;
#(
    parameter int unsigned LINE_PITCH = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cgb_cfg_t   cfg,
    input  logic       head_valid,
    input  glyph_job_t head,
    output logic       pop,
    cgb_pixel_if.source pixel
);

    localparam int unsigned PitchW = $clog2(LINE_PITCH + 1);
    localparam int unsigned SumW = CoordW + PitchW + 1;
    localparam logic [PitchW-1:0] Pitch = PitchW'(LINE_PITCH);

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [AddrW-1:0]   addr_reg;
    logic [AddrW-1:0]   addr_next;
    logic [ColourW-1:0] colour_reg;
    logic [ColourW-1:0] colour_next;
    logic               we_reg;
    logic               we_next;
    logic               last_reg;
    logic               last_next;
    logic [2:0]         col_reg;
    logic [2:0]         col_next;
    logic [2:0]         row_reg;
    logic [2:0]         row_next;

    logic               advance;
    logic               emit;
    logic               row_end;
    logic               item_end;
    logic [CoordW-1:0]  line;
    logic [SumW-1:0]    sum;
    logic [2:0]         byte_sel;
    logic [2:0]         bit_sel;
    logic [7:0]         row_bits;
    logic               on;
    logic               fg_on;
    logic               bg_on;

    assign pixel.valid         = out_valid_reg;
    assign pixel.pixel_address = addr_reg;
    assign pixel.pixel_colour  = colour_reg;
    assign pixel.write_enable  = we_reg;
    assign pixel.last_pixel    = last_reg;

    always_comb
    begin
        advance  = !out_valid_reg || pixel.ready;
        emit     = advance && head_valid;
        row_end  = (col_reg == head.x_last);
        item_end = row_end && (row_reg == head.y_last);
        pop      = emit && item_end;

        line     = head.y_row + CoordW'(row_reg);
        sum      = SumW'(line) * SumW'(Pitch) + SumW'(head.x_col) + SumW'(col_reg);
        byte_sel = row_reg + head.y_skip;
        bit_sel  = col_reg + head.x_skip;
        row_bits = head.glyph_rows[{byte_sel, 3'b000} +: 8];
        on       = row_bits[bit_sel];
        fg_on    = (cfg.trans_mode != TRANS_BG_ONLY);
        bg_on    = (cfg.trans_mode != TRANS_FG_ONLY);

        out_valid_next = out_valid_reg;
        addr_next      = addr_reg;
        colour_next    = colour_reg;
        we_next        = we_reg;
        last_next      = last_reg;
        col_next       = col_reg;
        row_next       = row_reg;

        if (advance)
        begin
            out_valid_next = head_valid;
        end

        if (emit)
        begin
            addr_next = AddrW'(sum);
            last_next = item_end;
            priority if (fg_on && on)
            begin
                colour_next = cfg.fore_colour;
                we_next     = 1'b1;
            end
            else if (bg_on && !on)
            begin
                colour_next = cfg.back_colour;
                we_next     = 1'b1;
            end
            else
            begin
                colour_next = '0;
                we_next     = 1'b0;
            end

            if (row_end)
            begin
                col_next = 3'd0;
                row_next = item_end ? 3'd0 : row_reg + 3'd1;
            end
            else
            begin
                col_next = col_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        colour_reg <= colour_next;
        we_reg     <= we_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            col_reg       <= 3'd0;
            row_reg       <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
        end
    end

endmodule

// ===== hw/rtl/clipped_glyph_blitter_top.sv =====
// Clipped 8x8 glyph blitter. Each item places one font character (position plus
// eight row bytes, row 0 in the low byte, bit 0 leftmost); the position is
// optionally scaled by 8 in grid mode, the cell is clipped against the inclusive
// window set by the configuration registers, and one pixel item per covered pixel
// comes out in row-major order with address row * LINE_PITCH + column (modulo
// 2^24), colour, write enable and a last-pixel flag. A character yields (visible
// width) * (visible height) pixel items, 64 at most. The pixel generator emits one
// pixel per cycle while the pixel sink is ready; fully clipped characters produce
// nothing and never reach it. A two-entry job queue lets placements be classified
// and accepted while earlier characters are still being drawn. Write configuration
// only while no character is in flight.
module clipped_glyph_blitter_top
    import cgb_pkg::*;
#(
    parameter int unsigned LINE_PITCH = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    cgb_place_if.sink           place,
    cgb_pixel_if.source         pixel
);

    cgb_cfg_t   cfg_reg;
    cgb_cfg_t   cfg_next;
    logic       visible;
    glyph_job_t job;
    logic       fifo_full;
    logic       push;
    logic       pop;
    logic       head_valid;
    glyph_job_t head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CLIP_LEFT:   cfg_next.clip_left   = cfg_data;
                CFG_CLIP_TOP:    cfg_next.clip_top    = cfg_data;
                CFG_CLIP_RIGHT:  cfg_next.clip_right  = cfg_data;
                CFG_CLIP_BOTTOM: cfg_next.clip_bottom = cfg_data;
                CFG_FORE_COLOUR: cfg_next.fore_colour = cfg_data[ColourW-1:0];
                CFG_BACK_COLOUR: cfg_next.back_colour = cfg_data[ColourW-1:0];
                CFG_TRANS_MODE:  cfg_next.trans_mode  = cfg_data[1:0];
                CFG_GRID_MODE:   cfg_next.grid_mode   = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clip_left   <= 12'd0;
            cfg_reg.clip_top    <= 12'd0;
            cfg_reg.clip_right  <= 12'd1023;
            cfg_reg.clip_bottom <= 12'd767;
            cfg_reg.fore_colour <= 8'd15;
            cfg_reg.back_colour <= 8'd0;
            cfg_reg.trans_mode  <= TRANS_BOTH;
            cfg_reg.grid_mode   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign place.ready = !fifo_full;
    assign push        = place.valid && !fifo_full && visible;

    cgb_front u_front
    (
        .cfg        (cfg_reg),
        .pos_x      (place.pos_x),
        .pos_y      (place.pos_y),
        .glyph_rows (place.glyph_rows),
        .visible    (visible),
        .job        (job)
    );

    cgb_job_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (job),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    cgb_back #(
        .LINE_PITCH (LINE_PITCH)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .pixel      (pixel)
    );

endmodule
